// ===== hw/rtl/ccsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccsr_pkg
// shared constants, codes and state type of the coordinate to sparse row core
// ----------------------------------------------------------------------------
`default_nettype none

package ccsr_pkg;

    // default sizes
    localparam int DEF_MAX_ROWS     = 1024;
    localparam int DEF_MAX_ENTRIES  = 4096;
    localparam int DEF_MAX_NONZEROS = 8192;
    localparam int DEF_VALUE_BITS   = 32;

    // field widths
    localparam int KIND_W   = 2;
    localparam int ROW_W    = 11;
    localparam int COL_W    = 17;
    localparam int VAL_W    = 32;
    localparam int RIDX_W   = 14;
    localparam int STS_W    = 3;
    localparam int TOTAL_W  = 14;
    localparam int RPTR_W   = 14;
    localparam int SCOL_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 4;

    localparam int COL_LIMIT = 65536;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RD_PTR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RD_NZ  = 2'd2;

    // status codes
    localparam logic [STS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STS_W-1:0] STS_BAD_ROW   = 3'd1;
    localparam logic [STS_W-1:0] STS_BAD_COL   = 3'd2;
    localparam logic [STS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STS_W-1:0] STS_BAD_INDEX = 3'd4;
    localparam logic [STS_W-1:0] STS_NOT_BUILT = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC = 1'b1;

    localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 11'd1024;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_PTR,
        S_RD_NZ,
        S_CLR,
        S_P_ERD,
        S_P_ELAT,
        S_P_ADDR,
        S_P_DAT,
        S_P_WR,
        S_PFX_INIT,
        S_PFX_RD,
        S_PFX_WR,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ccsr_ram.sv =====
// ----------------------------------------------------------------------------
// ccsr_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ccsr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/coo_to_csr_converter_core.sv =====
// ----------------------------------------------------------------------------
// coo_to_csr_converter_core
// builds a compressed sparse row matrix from streamed coordinate entries
// ----------------------------------------------------------------------------
// Load requests take one-based (row, column, value) entries, kept in input order,
// and answer with a registered status. The load marked last starts the build,
// and its answer comes when the build is done: a clear sweep of the per-row
// fill counters, a counting pass (an entry read and latch per entry, then an
// address, data and write step per placement, a mirror being a second
// placement in symmetric mode), a prefix sum into the row pointers (an init
// step, then a read and a write per row) and a scatter pass like the counting
// pass. The steps follow from the single read and write port of each memory
// and from one shared adder that does every fill increment, offset and running
// sum. A valid row pointer or nonzero read passes one memory read, a read state
// and the output register. One request is in work at a time and a new one is
// taken once the previous result has left the output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_to_csr_converter_core #(
    parameter int MAX_ROWS     = ccsr_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENTRIES  = ccsr_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_NONZEROS = ccsr_pkg::DEF_MAX_NONZEROS,
    parameter int VALUE_BITS   = ccsr_pkg::DEF_VALUE_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [ccsr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ccsr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // row_index, column_index, entry_value, read_index, zero pad
    input  wire logic [ccsr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind
    input  wire logic [ccsr_pkg::KIND_W-1:0]         s_axis_tuser,
    // last_entry
    input  wire logic                                s_axis_tlast,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // nonzero_total, row_pointer, stored_column, stored_value, zero pad
    output logic      [ccsr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status, build_done
    output logic      [ccsr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    // derived widths
    localparam int RW    = $clog2(MAX_ROWS + 1);      // row count
    localparam int RW0   = $clog2(MAX_ROWS);          // zero-based row
    localparam int FA_W  = $clog2(MAX_ROWS);          // fill counter address
    localparam int PA_W  = $clog2(MAX_ROWS + 1);      // row pointer address
    localparam int EC_W  = $clog2(MAX_ENTRIES + 1);   // entry count
    localparam int EA_W  = $clog2(MAX_ENTRIES);       // entry address
    localparam int NZ_W  = $clog2(MAX_NONZEROS + 1);  // counts, pointers
    localparam int NA_W  = $clog2(MAX_NONZEROS);      // nonzero address
    localparam int IX_W  = (EC_W > RW) ? EC_W : RW;   // loop index
    localparam int ENT_W = RW0 + ccsr_pkg::SCOL_W + VALUE_BITS;
    localparam int NZD_W = ccsr_pkg::SCOL_W + VALUE_BITS;

    // unpacked request fields
    logic [ccsr_pkg::ROW_W-1:0]  w_row;
    logic [ccsr_pkg::COL_W-1:0]  w_col;
    logic [ccsr_pkg::VAL_W-1:0]  w_val;
    logic [ccsr_pkg::RIDX_W-1:0] w_ridx;
    logic                        w_accept;

    assign w_row  = s_axis_tdata[10:0];
    assign w_col  = s_axis_tdata[27:11];
    assign w_val  = s_axis_tdata[59:28];
    assign w_ridx = s_axis_tdata[73:60];

    // control state
    ccsr_pkg::t_state r_state, n_state;
    logic [ccsr_pkg::ROW_W-1:0] r_row_count;
    logic                       r_sym;
    logic [EC_W-1:0]            r_entry_count;
    logic                       r_built;
    logic [RW-1:0]              r_built_rows;
    logic [NZ_W-1:0]            r_built_total;
    logic [IX_W-1:0]            r_idx;
    logic                       r_mir;
    logic                       r_scat;
    logic [NZ_W-1:0]            r_placed;
    logic [NZ_W-1:0]            r_acc;
    logic                       r_m_valid;

    // payload state
    logic [RW0-1:0]               r_ent_row;
    logic [ccsr_pkg::SCOL_W-1:0]  r_ent_col;
    logic [VALUE_BITS-1:0]        r_ent_val;
    logic [NZ_W-1:0]              r_fill;
    logic [NZ_W-1:0]              r_off;
    logic [ccsr_pkg::STS_W-1:0]   r_o_status;
    logic [ccsr_pkg::TOTAL_W-1:0] r_o_total;
    logic [ccsr_pkg::RPTR_W-1:0]  r_o_rptr;
    logic [ccsr_pkg::SCOL_W-1:0]  r_o_col;
    logic [ccsr_pkg::VAL_W-1:0]   r_o_val;
    logic                         r_o_done;

    // memory ports
    logic             w_ent_we;
    logic [EA_W-1:0]  w_ent_waddr, w_ent_raddr;
    logic [ENT_W-1:0] w_ent_wdata, w_ent_rdata;
    logic             w_fill_we;
    logic [FA_W-1:0]  w_fill_waddr, w_fill_raddr;
    logic [NZ_W-1:0]  w_fill_wdata, w_fill_rdata;
    logic             w_ptr_we;
    logic [PA_W-1:0]  w_ptr_waddr, w_ptr_raddr;
    logic [NZ_W-1:0]  w_ptr_wdata, w_ptr_rdata;
    logic             w_nz_we;
    logic [NA_W-1:0]  w_nz_waddr, w_nz_raddr;
    logic [NZD_W-1:0] w_nz_wdata, w_nz_rdata;

    // shared adder
    logic [NZ_W-1:0] w_add_a, w_add_b, w_sum;
    assign w_sum = w_add_a + w_add_b;

    // derived control values
    logic [RW-1:0]              w_rows;
    logic [EC_W-1:0]            w_ec_eff;
    logic [ccsr_pkg::STS_W-1:0] w_ld_status;
    logic                       w_rd_ptr_bad;
    logic                       w_rd_nz_bad;
    logic [IX_W-1:0]            w_idx_p1;
    logic                       w_ent_end;
    logic                       w_row_end;
    logic [RW0-1:0]             w_elat_row;
    logic                       w_own_ok;
    logic                       w_mirror_ok;
    logic [NZ_W-1:0]            w_placed_p1;
    logic [FA_W-1:0]            w_dst;
    logic [ccsr_pkg::SCOL_W-1:0] w_place_col;
    logic [ccsr_pkg::TOTAL_W-1:0] w_cur_total;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ccsr_pkg::S_IDLE) && !r_m_valid;

    // rows in use: zero acts as one, clipped at the row capacity
    always_comb begin
        if (r_row_count == '0) begin
            w_rows = RW'(1);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            w_rows = RW'(MAX_ROWS);
        end else begin
            w_rows = RW'(r_row_count);
        end
    end

    // a load after a finished build starts a new matrix
    assign w_ec_eff = r_built ? '0 : r_entry_count;

    always_comb begin
        if (w_row == '0 || 32'(w_row) > 32'(w_rows)) begin
            w_ld_status = ccsr_pkg::STS_BAD_ROW;
        end else if (w_col == '0 || 32'(w_col) > ccsr_pkg::COL_LIMIT
                     || (r_sym && 32'(w_col) > 32'(w_rows))) begin
            w_ld_status = ccsr_pkg::STS_BAD_COL;
        end else if (32'(w_ec_eff) >= MAX_ENTRIES) begin
            w_ld_status = ccsr_pkg::STS_FULL;
        end else begin
            w_ld_status = ccsr_pkg::STS_OK;
        end
    end

    assign w_rd_ptr_bad = 32'(w_ridx) > 32'(r_built_rows) || 32'(w_ridx) > MAX_ROWS;
    assign w_rd_nz_bad  = 32'(w_ridx) >= 32'(r_built_total)
                          || 32'(w_ridx) >= MAX_NONZEROS;

    assign w_idx_p1  = r_idx + 1'b1;
    assign w_ent_end = (32'(w_idx_p1) == 32'(r_entry_count));
    assign w_row_end = (32'(w_idx_p1) == 32'(w_rows));

    // entry just read: skip it when outside the rows or the store is full
    assign w_elat_row  = w_ent_rdata[ENT_W-1 -: RW0];
    assign w_own_ok    = (32'(w_elat_row) < 32'(w_rows)) && (32'(r_placed) < MAX_NONZEROS);
    assign w_placed_p1 = r_placed + 1'b1;
    assign w_mirror_ok = r_sym && (32'(r_ent_col) != 32'(r_ent_row))
                         && (32'(r_ent_col) < 32'(w_rows))
                         && (32'(w_placed_p1) < MAX_NONZEROS);

    // destination row and stored column of the current placement
    assign w_dst       = r_mir ? FA_W'(r_ent_col) : FA_W'(r_ent_row);
    assign w_place_col = r_mir ? ccsr_pkg::SCOL_W'(r_ent_row) : r_ent_col;

    assign w_cur_total = r_built ? ccsr_pkg::TOTAL_W'(r_built_total) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ccsr_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tuser)
                        ccsr_pkg::KIND_LOAD: begin
                            if (s_axis_tlast) begin
                                n_state = ccsr_pkg::S_CLR;
                            end
                        end
                        ccsr_pkg::KIND_RD_PTR: begin
                            if (r_built && !w_rd_ptr_bad) begin
                                n_state = ccsr_pkg::S_RD_PTR;
                            end
                        end
                        ccsr_pkg::KIND_RD_NZ: begin
                            if (r_built && !w_rd_nz_bad) begin
                                n_state = ccsr_pkg::S_RD_NZ;
                            end
                        end
                        default: n_state = ccsr_pkg::S_IDLE;
                    endcase
                end
            end
            ccsr_pkg::S_RD_PTR, ccsr_pkg::S_RD_NZ, ccsr_pkg::S_FIN: begin
                n_state = ccsr_pkg::S_IDLE;
            end
            ccsr_pkg::S_CLR: begin
                if (w_row_end) begin
                    n_state = (r_entry_count == '0) ? ccsr_pkg::S_PFX_INIT
                                                    : ccsr_pkg::S_P_ERD;
                end
            end
            ccsr_pkg::S_P_ERD: n_state = ccsr_pkg::S_P_ELAT;
            ccsr_pkg::S_P_ELAT: begin
                if (w_own_ok) begin
                    n_state = ccsr_pkg::S_P_ADDR;
                end else if (!w_ent_end) begin
                    n_state = ccsr_pkg::S_P_ERD;
                end else begin
                    n_state = r_scat ? ccsr_pkg::S_FIN : ccsr_pkg::S_PFX_INIT;
                end
            end
            ccsr_pkg::S_P_ADDR: n_state = ccsr_pkg::S_P_DAT;
            ccsr_pkg::S_P_DAT:  n_state = ccsr_pkg::S_P_WR;
            ccsr_pkg::S_P_WR: begin
                if (!r_mir && w_mirror_ok) begin
                    n_state = ccsr_pkg::S_P_ADDR;
                end else if (!w_ent_end) begin
                    n_state = ccsr_pkg::S_P_ERD;
                end else begin
                    n_state = r_scat ? ccsr_pkg::S_FIN : ccsr_pkg::S_PFX_INIT;
                end
            end
            ccsr_pkg::S_PFX_INIT: n_state = ccsr_pkg::S_PFX_RD;
            ccsr_pkg::S_PFX_RD:   n_state = ccsr_pkg::S_PFX_WR;
            ccsr_pkg::S_PFX_WR: begin
                if (w_row_end) begin
                    n_state = (r_entry_count == '0) ? ccsr_pkg::S_FIN
                                                    : ccsr_pkg::S_P_ERD;
                end else begin
                    n_state = ccsr_pkg::S_PFX_RD;
                end
            end
            default: n_state = ccsr_pkg::S_IDLE;
        endcase
    end

    // memory and adder control
    always_comb begin
        w_ent_we     = 1'b0;
        w_ent_waddr  = EA_W'(w_ec_eff);
        w_ent_wdata  = {RW0'(w_row - 1'b1), ccsr_pkg::SCOL_W'(w_col - 1'b1),
                        VALUE_BITS'(w_val)};
        w_ent_raddr  = EA_W'(r_idx);
        w_fill_we    = 1'b0;
        w_fill_waddr = w_dst;
        w_fill_wdata = '0;
        w_fill_raddr = w_dst;
        w_ptr_we     = 1'b0;
        w_ptr_waddr  = PA_W'(w_idx_p1);
        w_ptr_wdata  = w_sum;
        w_ptr_raddr  = PA_W'(w_dst);
        w_nz_we      = 1'b0;
        w_nz_waddr   = NA_W'(r_off);
        w_nz_wdata   = {w_place_col, r_ent_val};
        w_nz_raddr   = NA_W'(w_ridx);
        w_add_a      = '0;
        w_add_b      = '0;
        case (r_state)
            ccsr_pkg::S_IDLE: begin
                // reads are steered by the incoming index
                w_ptr_raddr = PA_W'(w_ridx);
                w_ent_we    = w_accept && (s_axis_tuser == ccsr_pkg::KIND_LOAD)
                              && (w_ld_status == ccsr_pkg::STS_OK);
            end
            ccsr_pkg::S_CLR: begin
                w_fill_we    = 1'b1;
                w_fill_waddr = FA_W'(r_idx);
            end
            ccsr_pkg::S_P_DAT: begin
                // offset of this placement in the scatter pass
                w_add_a = w_ptr_rdata;
                w_add_b = w_fill_rdata;
            end
            ccsr_pkg::S_P_WR: begin
                w_add_a      = r_fill;
                w_add_b      = NZ_W'(1);
                w_fill_we    = 1'b1;
                w_fill_wdata = w_sum;
                w_nz_we      = r_scat && (32'(r_off) < MAX_NONZEROS);
            end
            ccsr_pkg::S_PFX_INIT: begin
                w_ptr_we    = 1'b1;
                w_ptr_waddr = '0;
                w_ptr_wdata = '0;
            end
            ccsr_pkg::S_PFX_RD: begin
                w_fill_raddr = FA_W'(r_idx);
            end
            ccsr_pkg::S_PFX_WR: begin
                // running sum, and the counter is cleared for the scatter
                w_add_a      = r_acc;
                w_add_b      = w_fill_rdata;
                w_ptr_we     = 1'b1;
                w_fill_we    = 1'b1;
                w_fill_waddr = FA_W'(r_idx);
                w_fill_wdata = '0;
            end
            default: begin
                w_fill_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ccsr_pkg::S_IDLE;
            r_row_count   <= ccsr_pkg::ROW_COUNT_RESET;
            r_sym         <= 1'b0;
            r_entry_count <= '0;
            r_built       <= 1'b0;
            r_built_rows  <= '0;
            r_built_total <= '0;
            r_idx         <= '0;
            r_mir         <= 1'b0;
            r_scat        <= 1'b0;
            r_placed      <= '0;
            r_acc         <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ccsr_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    ccsr_pkg::CFG_SYMMETRIC: r_sym <= i_cfg_data[0];
                    default: r_sym <= r_sym;
                endcase
            end
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ccsr_pkg::S_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser == ccsr_pkg::KIND_LOAD) begin
                            r_built <= 1'b0;
                            r_entry_count <= (w_ld_status == ccsr_pkg::STS_OK)
                                             ? EC_W'(w_ec_eff + 1'b1) : w_ec_eff;
                            r_idx    <= '0;
                            r_mir    <= 1'b0;
                            r_scat   <= 1'b0;
                            r_placed <= '0;
                            r_m_valid <= !s_axis_tlast;
                        end else begin
                            r_m_valid <= (n_state == ccsr_pkg::S_IDLE);
                        end
                    end
                end
                ccsr_pkg::S_CLR: begin
                    r_idx <= w_row_end ? '0 : w_idx_p1;
                end
                ccsr_pkg::S_P_ELAT: begin
                    r_mir <= 1'b0;
                    if (!w_own_ok) begin
                        r_idx <= w_idx_p1;
                    end
                end
                ccsr_pkg::S_P_WR: begin
                    r_placed <= w_placed_p1;
                    if (!r_mir && w_mirror_ok) begin
                        r_mir <= 1'b1;
                    end else begin
                        r_idx <= w_idx_p1;
                    end
                end
                ccsr_pkg::S_PFX_INIT: begin
                    r_acc <= '0;
                    r_idx <= '0;
                end
                ccsr_pkg::S_PFX_WR: begin
                    r_acc <= w_sum;
                    if (w_row_end) begin
                        r_idx    <= '0;
                        r_scat   <= 1'b1;
                        r_placed <= '0;
                    end else begin
                        r_idx <= w_idx_p1;
                    end
                end
                ccsr_pkg::S_FIN: begin
                    r_built       <= 1'b1;
                    r_built_rows  <= w_rows;
                    r_built_total <= r_acc;
                    r_m_valid     <= 1'b1;
                end
                ccsr_pkg::S_RD_PTR, ccsr_pkg::S_RD_NZ: begin
                    r_m_valid <= 1'b1;
                end
                default: begin
                    r_mir <= r_mir;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ccsr_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_o_rptr <= '0;
                    r_o_col  <= '0;
                    r_o_val  <= '0;
                    if (s_axis_tuser == ccsr_pkg::KIND_LOAD) begin
                        r_o_status <= w_ld_status;
                        r_o_total  <= '0;
                        r_o_done   <= 1'b0;
                    end else begin
                        r_o_total <= w_cur_total;
                        r_o_done  <= r_built;
                        if (s_axis_tuser == ccsr_pkg::KIND_RD_PTR) begin
                            r_o_status <= !r_built ? ccsr_pkg::STS_NOT_BUILT
                                        : (w_rd_ptr_bad ? ccsr_pkg::STS_BAD_INDEX
                                                        : ccsr_pkg::STS_OK);
                        end else if (s_axis_tuser == ccsr_pkg::KIND_RD_NZ) begin
                            r_o_status <= !r_built ? ccsr_pkg::STS_NOT_BUILT
                                        : (w_rd_nz_bad ? ccsr_pkg::STS_BAD_INDEX
                                                       : ccsr_pkg::STS_OK);
                        end else begin
                            r_o_status <= ccsr_pkg::STS_BAD_INDEX;
                        end
                    end
                end
            end
            ccsr_pkg::S_P_ELAT: begin
                r_ent_row <= w_elat_row;
                r_ent_col <= w_ent_rdata[VALUE_BITS +: ccsr_pkg::SCOL_W];
                r_ent_val <= w_ent_rdata[VALUE_BITS-1:0];
            end
            ccsr_pkg::S_P_DAT: begin
                r_fill <= w_fill_rdata;
                r_off  <= w_sum;
            end
            ccsr_pkg::S_FIN: begin
                r_o_total <= ccsr_pkg::TOTAL_W'(r_acc);
                r_o_done  <= 1'b1;
            end
            ccsr_pkg::S_RD_PTR: begin
                r_o_rptr <= ccsr_pkg::RPTR_W'(w_ptr_rdata);
            end
            ccsr_pkg::S_RD_NZ: begin
                r_o_col <= w_nz_rdata[NZD_W-1 -: ccsr_pkg::SCOL_W];
                r_o_val <= ccsr_pkg::VAL_W'(w_nz_rdata[VALUE_BITS-1:0]);
            end
            default: begin
                r_o_done <= r_o_done;
            end
        endcase
    end

    // entry store in input order
    ccsr_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(ENT_W)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    // per-row fill counters
    ccsr_ram #(.DEPTH(MAX_ROWS), .WIDTH(NZ_W)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_fill_waddr),
        .i_wdata (w_fill_wdata),
        .i_raddr (w_fill_raddr),
        .o_rdata (w_fill_rdata)
    );

    // row pointers
    ccsr_ram #(.DEPTH(MAX_ROWS + 1), .WIDTH(NZ_W)) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (w_ptr_we),
        .i_waddr (w_ptr_waddr),
        .i_wdata (w_ptr_wdata),
        .i_raddr (w_ptr_raddr),
        .o_rdata (w_ptr_rdata)
    );

    // compressed columns and values
    ccsr_ram #(.DEPTH(MAX_NONZEROS), .WIDTH(NZD_W)) u_nz_ram (
        .i_clk   (i_clk),
        .i_we    (w_nz_we),
        .i_waddr (w_nz_waddr),
        .i_wdata (w_nz_wdata),
        .i_raddr (w_nz_raddr),
        .o_rdata (w_nz_rdata)
    );

    // result stream
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'd0, r_o_val, r_o_col, r_o_rptr, r_o_total};
    assign m_axis_tuser  = {r_o_done, r_o_status};

`ifndef SYNTHESIS
    // the latched total never exceeds the nonzero store
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> (32'(r_built_total) <= MAX_NONZEROS))
        else $error("built total above nonzero capacity");

    // entry count stays within the entry store
    a_entry_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_entry_count) <= MAX_ENTRIES)
        else $error("entry count above capacity");

    // a plain load answers next cycle with the matrix marked not built
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == ccsr_pkg::KIND_LOAD && !s_axis_tlast)
        |=> (m_axis_tvalid && !m_axis_tuser[3] && m_axis_tdata[13:0] == '0))
        else $error("load answer wrong");

    // the end of a build publishes the result
    a_build_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ccsr_pkg::S_FIN) |=> (r_built && m_axis_tvalid && m_axis_tuser[3]))
        else $error("build end not published");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_coo_to_csr_converter_core.sv =====
// ----------------------------------------------------------------------------
// tb_coo_to_csr_converter_core
// self-checking bench for the coordinate to compressed sparse row core
// ----------------------------------------------------------------------------
// A directed table covers reset reads, field extremes, rejected loads and the
// first build; a randomized part then loads many small matrices under changing
// row counts and symmetric mode and reads them back. Results are compared in
// order, typed rows against their table status, all else against an in-bench
// model of the build (count, exclusive prefix sum, stable scatter with mirrors).
// ----------------------------------------------------------------------------
`default_nettype none

module tb_coo_to_csr_converter_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ROWS = ccsr_pkg::DEF_MAX_ROWS;
    localparam int N_ENT  = ccsr_pkg::DEF_MAX_ENTRIES;
    localparam int N_NZ   = ccsr_pkg::DEF_MAX_NONZEROS;

    // request kinds and status codes
    localparam logic [ccsr_pkg::KIND_W-1:0] KIND_LOAD   = ccsr_pkg::KIND_LOAD;
    localparam logic [ccsr_pkg::KIND_W-1:0] KIND_RD_PTR = ccsr_pkg::KIND_RD_PTR;
    localparam logic [ccsr_pkg::KIND_W-1:0] KIND_RD_NZ  = ccsr_pkg::KIND_RD_NZ;
    localparam logic [ccsr_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [ccsr_pkg::STS_W-1:0]  STS_OK        = ccsr_pkg::STS_OK;
    localparam logic [ccsr_pkg::STS_W-1:0]  STS_BAD_ROW   = ccsr_pkg::STS_BAD_ROW;
    localparam logic [ccsr_pkg::STS_W-1:0]  STS_BAD_COL   = ccsr_pkg::STS_BAD_COL;
    localparam logic [ccsr_pkg::STS_W-1:0]  STS_FULL      = ccsr_pkg::STS_FULL;
    localparam logic [ccsr_pkg::STS_W-1:0]  STS_BAD_INDEX = ccsr_pkg::STS_BAD_INDEX;
    localparam logic [ccsr_pkg::STS_W-1:0]  STS_NOT_BUILT = ccsr_pkg::STS_NOT_BUILT;

    // one request as the bench sees it
    typedef struct {
        logic [ccsr_pkg::KIND_W-1:0] kind;
        logic [ccsr_pkg::ROW_W-1:0]  row;
        logic [ccsr_pkg::COL_W-1:0]  col;
        logic [ccsr_pkg::VAL_W-1:0]  val;
        logic                        last;
        logic [ccsr_pkg::RIDX_W-1:0] ridx;
    } csr_req_t;

    // one answer
    typedef struct packed {
        logic [ccsr_pkg::STS_W-1:0]   sts;
        logic [ccsr_pkg::TOTAL_W-1:0] total;
        logic [ccsr_pkg::RPTR_W-1:0]  rptr;
        logic [ccsr_pkg::SCOL_W-1:0]  scol;
        logic [ccsr_pkg::VAL_W-1:0]   sval;
        logic                         done;
    } csr_reply_t;

    // directed row: typed rows carry their status, all other fields zero
    typedef struct {
        logic [ccsr_pkg::KIND_W-1:0] kind;
        logic [ccsr_pkg::ROW_W-1:0]  row;
        logic [ccsr_pkg::COL_W-1:0]  col;
        logic [ccsr_pkg::VAL_W-1:0]  val;
        logic                        last;
        logic [ccsr_pkg::RIDX_W-1:0] ridx;
        bit                          typed;
        logic [ccsr_pkg::STS_W-1:0]  sts;
    } dir_row_t;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [ccsr_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [ccsr_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ccsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ccsr_pkg::KIND_W-1:0]      s_axis_tuser = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ccsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [ccsr_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

    coo_to_csr_converter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the block: config, entry store, built matrix
    // ------------------------------------------------------------------
    logic [ccsr_pkg::ROW_W-1:0] sh_row_count = ccsr_pkg::ROW_COUNT_RESET;
    logic                       sh_sym = 1'b0;
    logic [9:0]                 ent_row [N_ENT];
    logic [15:0]                ent_col [N_ENT];
    logic [ccsr_pkg::VAL_W-1:0] ent_val [N_ENT];
    int                         ent_cnt = 0;
    int                         fill_cnt [N_ROWS+1];
    int                         row_ptr [N_ROWS+1];
    logic [15:0]                nz_col [N_NZ];
    logic [ccsr_pkg::VAL_W-1:0] nz_val [N_NZ];
    bit                         is_built = 1'b0;
    int                         built_rows = 0;
    int                         built_total = 0;

    csr_reply_t expected_replies [$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    function automatic int rows_eff();
        if (sh_row_count == 0) return 1;
        if (sh_row_count > N_ROWS) return N_ROWS;
        return int'(sh_row_count);
    endfunction

    // one pass over the held entries; counts or scatters placements
    function automatic void place_entries(int rows, bit sym, bit scatter);
        int placed;
        int r;
        int c;
        int dst;
        int off;
        placed = 0;
        for (int k = 0; k <= N_ROWS; k++) fill_cnt[k] = 0;
        for (int i = 0; i < ent_cnt; i++) begin
            r = ent_row[i];
            c = ent_col[i];
            if (r >= rows) continue;
            for (int m = 0; m < 2; m++) begin
                // mirror only off-diagonal entries whose column is a row in use
                if (m == 1 && (!sym || c == r || c >= rows)) break;
                if (placed >= N_NZ) break;
                dst = (m == 0) ? r : c;
                if (scatter) begin
                    off = row_ptr[dst] + fill_cnt[dst];
                    if (off < N_NZ) begin
                        nz_col[off] = 16'((m == 0) ? c : r);
                        nz_val[off] = ent_val[i];
                    end
                end
                fill_cnt[dst]++;
                placed++;
            end
        end
    endfunction

    function automatic void build_matrix();
        int rows;
        rows = rows_eff();
        place_entries(rows, sh_sym, 1'b0);
        row_ptr[0] = 0;
        for (int i = 0; i < rows; i++) row_ptr[i+1] = row_ptr[i] + fill_cnt[i];
        place_entries(rows, sh_sym, 1'b1);
        built_rows = rows;
        built_total = row_ptr[rows];
        is_built = 1'b1;
    endfunction

    function automatic csr_reply_t predict_reply(csr_req_t q);
        csr_reply_t p;
        int rows;
        p = '0;
        case (q.kind)
            KIND_LOAD: begin
                // a load after a build opens a new matrix
                if (is_built) begin
                    is_built = 1'b0;
                    ent_cnt = 0;
                    built_total = 0;
                end
                rows = rows_eff();
                if (q.row == 0 || q.row > rows) p.sts = STS_BAD_ROW;
                else if (q.col == 0 || q.col > ccsr_pkg::COL_LIMIT
                         || (sh_sym && q.col > rows))
                    p.sts = STS_BAD_COL;
                else if (ent_cnt >= N_ENT) p.sts = STS_FULL;
                else begin
                    ent_row[ent_cnt] = 10'(q.row - 1);
                    ent_col[ent_cnt] = 16'(q.col - 1);
                    ent_val[ent_cnt] = q.val;
                    ent_cnt++;
                end
                // last mark starts the build even on a dropped entry
                if (q.last) build_matrix();
            end
            KIND_RD_PTR: begin
                if (!is_built) p.sts = STS_NOT_BUILT;
                else if (q.ridx > built_rows) p.sts = STS_BAD_INDEX;
                else p.rptr = ccsr_pkg::RPTR_W'(row_ptr[q.ridx]);
            end
            KIND_RD_NZ: begin
                if (!is_built) p.sts = STS_NOT_BUILT;
                else if (q.ridx >= built_total) p.sts = STS_BAD_INDEX;
                else begin
                    p.scol = nz_col[q.ridx];
                    p.sval = nz_val[q.ridx];
                end
            end
            default: p.sts = STS_BAD_INDEX;
        endcase
        p.total = is_built ? ccsr_pkg::TOTAL_W'(built_total) : '0;
        p.done  = is_built;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_request(csr_req_t q, bit typed,
                                logic [ccsr_pkg::STS_W-1:0] typed_sts);
        int gap;
        csr_reply_t p;
        csr_reply_t t;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // tdata: row_index, column_index, entry_value, read_index, zero pad
        s_axis_tdata  <= {6'd0, q.ridx, q.val, q.col, q.row};
        s_axis_tuser  <= q.kind;
        s_axis_tlast  <= q.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        p = predict_reply(q);
        if (typed) begin
            t = '0;
            t.sts = typed_sts;
            expected_replies.push_back(t);
        end else begin
            expected_replies.push_back(p);
        end
    endtask

    // drain all answers, then give the core time to settle
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // one write, then a wait with the enable low
    task automatic write_cfg(logic [ccsr_pkg::CFG_IDX_W-1:0] idx,
                             logic [ccsr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ccsr_pkg::CFG_ROW_COUNT) sh_row_count = data;
        else sh_sym = data[0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and in-order compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        csr_reply_t got;
        csr_reply_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            // tdata: nonzero_total, row_pointer, stored_column, stored_value
            // tuser: status, build_done
            got.total = m_axis_tdata[13:0];
            got.rptr  = m_axis_tdata[27:14];
            got.scol  = m_axis_tdata[43:28];
            got.sval  = m_axis_tdata[75:44];
            got.sts   = m_axis_tuser[2:0];
            got.done  = m_axis_tuser[3];
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result sts=%0d total=%0d", got.sts, got.total);
            end else begin
                want = expected_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp sts=%0d tot=%0d rp=%0d col=%0d val=%h done=%0d",
                                  " | got sts=%0d tot=%0d rp=%0d col=%0d val=%h done=%0d"},
                                 want.sts, want.total, want.rptr, want.scol, want.sval,
                                 want.done, got.sts, got.total, got.rptr, got.scol,
                                 got.sval, got.done);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    dir_row_t dir_table [24] = '{
        // reads before any build, and the unused kind
        '{KIND_RD_PTR, 11'd0,    17'd0,      32'h0,        1'b0, 14'd0,     1'b1, STS_NOT_BUILT},
        '{KIND_RD_NZ,  11'd0,    17'd0,      32'h0,        1'b0, 14'd16383, 1'b1, STS_NOT_BUILT},
        '{KIND_UNUSED, 11'd2047, 17'd131071, 32'hFFFFFFFF, 1'b0, 14'd16383, 1'b1, STS_BAD_INDEX},
        // bad rows
        '{KIND_LOAD,   11'd0,    17'd1,      32'h1,        1'b0, 14'd0,     1'b1, STS_BAD_ROW},
        '{KIND_LOAD,   11'd1025, 17'd1,      32'h1,        1'b0, 14'd0,     1'b1, STS_BAD_ROW},
        '{KIND_LOAD,   11'd2047, 17'd1,      32'h1,        1'b0, 14'd0,     1'b1, STS_BAD_ROW},
        // bad columns
        '{KIND_LOAD,   11'd1,    17'd0,      32'h1,        1'b0, 14'd0,     1'b1, STS_BAD_COL},
        '{KIND_LOAD,   11'd1,    17'd65537,  32'h1,        1'b0, 14'd0,     1'b1, STS_BAD_COL},
        '{KIND_LOAD,   11'd1,    17'd131071, 32'h1,        1'b0, 14'd0,     1'b1, STS_BAD_COL},
        // good loads at the extremes
        '{KIND_LOAD,   11'd1024, 17'd65536,  32'h7FFFFFFF, 1'b0, 14'd16383, 1'b1, STS_OK},
        '{KIND_LOAD,   11'd1,    17'd1,      32'h80000000, 1'b0, 14'd0,     1'b1, STS_OK},
        '{KIND_LOAD,   11'd1,    17'd3,      32'hFFFFFFFF, 1'b0, 14'd0,     1'b1, STS_OK},
        '{KIND_LOAD,   11'd5,    17'd2,      32'h0,        1'b1, 14'd0,     1'b0, STS_OK},
        // reads of the built matrix
        '{KIND_RD_PTR, 11'd0,    17'd0,      32'h0,        1'b0, 14'd0,     1'b0, STS_OK},
        '{KIND_RD_PTR, 11'd5,    17'd0,      32'h0,        1'b0, 14'd1,     1'b0, STS_OK},
        '{KIND_RD_PTR, 11'd0,    17'd0,      32'h0,        1'b0, 14'd1024,  1'b0, STS_OK},
        '{KIND_RD_PTR, 11'd0,    17'd0,      32'h0,        1'b0, 14'd1025,  1'b0, STS_OK},
        '{KIND_RD_NZ,  11'd0,    17'd0,      32'h0,        1'b0, 14'd0,     1'b0, STS_OK},
        '{KIND_RD_NZ,  11'd0,    17'd0,      32'h0,        1'b0, 14'd2,     1'b0, STS_OK},
        '{KIND_RD_NZ,  11'd0,    17'd0,      32'h0,        1'b0, 14'd3,     1'b0, STS_OK},
        '{KIND_RD_NZ,  11'd0,    17'd0,      32'h0,        1'b0, 14'd4,     1'b0, STS_OK},
        '{KIND_RD_NZ,  11'd0,    17'd0,      32'h0,        1'b0, 14'd16383, 1'b0, STS_OK},
        // rejected entry carrying the last mark: empty matrix is built
        '{KIND_LOAD,   11'd0,    17'd1,      32'h5,        1'b1, 14'd0,     1'b0, STS_OK},
        '{KIND_RD_NZ,  11'd0,    17'd0,      32'h0,        1'b0, 14'd0,     1'b0, STS_OK}
    };

    // ------------------------------------------------------------------
    // random matrix: config, loads (with early reads), then reads back
    // ------------------------------------------------------------------
    task automatic random_matrix();
        csr_req_t q;
        int n_ent;
        int rows;
        int sel;
        sel = $urandom_range(99);
        wait_quiet();
        if (sel < 10)      write_cfg(ccsr_pkg::CFG_ROW_COUNT, 11'd1024);
        else if (sel < 15) write_cfg(ccsr_pkg::CFG_ROW_COUNT, 11'd0);
        else if (sel < 20) write_cfg(ccsr_pkg::CFG_ROW_COUNT, 11'd2047);
        else if (sel < 30) write_cfg(ccsr_pkg::CFG_ROW_COUNT, 11'd1);
        else               write_cfg(ccsr_pkg::CFG_ROW_COUNT, 11'($urandom_range(16, 2)));
        write_cfg(ccsr_pkg::CFG_SYMMETRIC, {10'($urandom), 1'($urandom_range(1))});
        n_ent = $urandom_range(20, 1);
        for (int i = 0; i < n_ent; i++) begin
            // occasionally change the row count mid-load so the build skips entries
            if ($urandom_range(99) < 4) begin
                wait_quiet();
                write_cfg(ccsr_pkg::CFG_ROW_COUNT, 11'($urandom_range(16, 1)));
            end
            rows = rows_eff();
            q.kind = KIND_LOAD;
            q.row  = 11'($urandom_range(rows, 1));
            q.col  = 17'($urandom_range((rows < 64) ? rows + (sh_sym ? 0 : 2) : 64, 1));
            q.val  = $urandom;
            q.ridx = 14'($urandom);
            q.last = (i == n_ent - 1);
            sel = $urandom_range(99);
            if (sel < 5)       q.row = 11'($urandom);
            else if (sel < 10) q.col = 17'($urandom);
            else if (sel < 13) q.col = 17'($urandom_range(ccsr_pkg::COL_LIMIT, 1));
            else if (sel < 16) q.kind = 2'($urandom_range(3, 1));
            if (q.kind != KIND_LOAD && q.last) begin
                send_request(q, 1'b0, STS_OK);
                q.kind = KIND_LOAD;
            end
            send_request(q, 1'b0, STS_OK);
        end
        for (int i = $urandom_range(15, 6); i > 0; i--) begin
            q.kind = 2'($urandom_range(2, 1));
            q.row  = 11'($urandom);
            q.col  = 17'($urandom);
            q.val  = $urandom;
            q.last = 1'($urandom);
            sel = $urandom_range(99);
            if (sel < 8)       q.ridx = 14'($urandom);
            else if (sel < 12) q.kind = KIND_UNUSED;
            else if (q.kind == KIND_RD_PTR) q.ridx = 14'($urandom_range(built_rows + 1));
            else q.ridx = 14'($urandom_range(built_total + 1));
            send_request(q, 1'b0, STS_OK);
        end
    endtask

    initial begin
        csr_req_t q;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 27;
        recv_idle_pct = 73;
        foreach (dir_table[i]) begin
            q.kind = dir_table[i].kind;
            q.row  = dir_table[i].row;
            q.col  = dir_table[i].col;
            q.val  = dir_table[i].val;
            q.last = dir_table[i].last;
            q.ridx = dir_table[i].ridx;
            send_request(q, dir_table[i].typed, dir_table[i].sts);
        end

        // three idling profiles over the random matrices
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 73 : 0;
            recv_idle_pct = (mode == 0) ? 73 : (mode == 1) ? 27 : 0;
            while (items_sent < 24 + (mode + 1) * 360) random_matrix();
        end

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/ccsr_pkg.sv
hw/rtl/ccsr_ram.sv
hw/rtl/coo_to_csr_converter_core.sv
verif/tb_coo_to_csr_converter_core.sv
